>>> hw/rtl/ggc_pkg.sv
package ggc_pkg;

  // Graph size and color limits.
  localparam int MAX_VERTICES = 65536;
  localparam int MAX_COLORS   = 254;

  // Field widths.
  localparam int VID_W   = 16;
  localparam int COLOR_W = 8;
  localparam int POP_W   = 17;
  localparam int VTX_AW  = $clog2(MAX_VERTICES);

  // Color codes and limits.
  localparam logic [COLOR_W-1:0] UNCOLORED = 8'hFF;
  localparam logic [POP_W-1:0]   POP_MAX   = {POP_W{1'b1}};

  // First-free search walks the blocked set one chunk per cycle.
  localparam int CHUNK      = 16;
  localparam int CHUNK_W    = $clog2(CHUNK);
  localparam int NUM_CHUNKS = (MAX_COLORS + CHUNK - 1) / CHUNK;
  localparam int SCAN_W     = $clog2(NUM_CHUNKS);
  localparam int PAD_W      = NUM_CHUNKS * CHUNK;

  // Sequencer states.
  typedef enum logic [7:0] {
    ST_CLEAR = 8'b0000_0001,
    ST_IDLE  = 8'b0000_0010,
    ST_NRD   = 8'b0000_0100,
    ST_SCAN  = 8'b0000_1000,
    ST_VCHK  = 8'b0001_0000,
    ST_ODEC  = 8'b0010_0000,
    ST_CRD   = 8'b0100_0000,
    ST_CINC  = 8'b1000_0000
  } state_t;

endpackage

>>> hw/rtl/greedy_graph_coloring_core.sv
// First-fit greedy graph coloring core.
// Input requests: one per neighbor of a vertex (in_vertex_id, in_neighbor_id,
// in_has_neighbor, in_last_neighbor); a vertex without neighbors is one request
// with in_has_neighbor low. A request is taken when start is high and busy low.
// A request without in_last_neighbor reads the neighbor's color from the table,
// then marks that color blocked. A request with in_last_neighbor does the same,
// then the first-free search walks the blocked set 16 colors per cycle, then,
// unless the core is out of colors, the vertex color table and the population
// memory are updated through their single ports (read old color, lower its count,
// read and raise the new color's count).
// The result comes out on out_* with out_valid high for exactly one cycle, the
// first cycle with busy low; the receiver cannot stall, so results are never
// held. A new request may be started in the cycle in which out_valid is high.
// After reset the color table is swept to uncolored, one entry per cycle, over its
// 65536 entries with busy high. The color count and blocked set start empty; the
// population memory is not cleared; a newly opened color starts its count at one.
module greedy_graph_coloring_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [ggc_pkg::VID_W-1:0]   in_vertex_id,
  input  logic [ggc_pkg::VID_W-1:0]   in_neighbor_id,
  input  logic                        in_has_neighbor,
  input  logic                        in_last_neighbor,
  output logic                        out_valid,
  output logic [ggc_pkg::VID_W-1:0]   out_colored_vertex,
  output logic [ggc_pkg::COLOR_W-1:0] out_assigned_color,
  output logic [ggc_pkg::COLOR_W-1:0] out_colors_in_use,
  output logic [ggc_pkg::POP_W-1:0]   out_color_population,
  output logic                        out_out_of_colors
);

  ggc_pkg::state_t state_r, state_nxt;

  logic [ggc_pkg::VTX_AW-1:0]     clr_r, clr_nxt;
  logic [ggc_pkg::SCAN_W-1:0]     scan_r, scan_nxt;
  logic [ggc_pkg::COLOR_W-1:0]    chosen_r, chosen_nxt;
  logic                           new_color_r, new_color_nxt;
  logic [ggc_pkg::COLOR_W-1:0]    old_r, old_nxt;
  logic [ggc_pkg::COLOR_W-1:0]    color_count_r, color_count_nxt;
  logic [ggc_pkg::MAX_COLORS-1:0] blocked_r, blocked_nxt;

  // Latched request payload.
  logic [ggc_pkg::VID_W-1:0] vid_r;
  logic                      vid_ok_r;
  logic                      nb_ok_r;
  logic                      last_r;

  // Result registers.
  logic                        out_valid_r;
  logic [ggc_pkg::VID_W-1:0]   out_vertex_r;
  logic [ggc_pkg::COLOR_W-1:0] out_color_r, out_color_nxt;
  logic [ggc_pkg::COLOR_W-1:0] out_count_r;
  logic [ggc_pkg::POP_W-1:0]   out_pop_r, out_pop_nxt;
  logic                        out_oob_r, out_oob_nxt;
  logic                        out_load;

  // Vertex color table and per-color population memory.
  logic [ggc_pkg::COLOR_W-1:0] tbl_mem [ggc_pkg::MAX_VERTICES];
  logic [ggc_pkg::VTX_AW-1:0]  tbl_raddr, tbl_waddr;
  logic [ggc_pkg::COLOR_W-1:0] tbl_rdata, tbl_wdata;
  logic                        tbl_we;

  logic [ggc_pkg::POP_W-1:0]   pop_mem [ggc_pkg::MAX_COLORS];
  logic [ggc_pkg::COLOR_W-1:0] pop_raddr, pop_waddr;
  logic [ggc_pkg::POP_W-1:0]   pop_rdata, pop_wdata;
  logic                        pop_we;

  // Search helpers.
  logic [ggc_pkg::PAD_W-1:0]   blk_pad;
  logic [ggc_pkg::CHUNK-1:0]   free_bits;
  logic [ggc_pkg::CHUNK_W-1:0] pick;
  logic                        found;
  logic [ggc_pkg::COLOR_W-1:0] cidx;
  logic                        accept;
  logic                        old_ok;

  assign accept = start && (state_r == ggc_pkg::ST_IDLE);
  assign busy   = (state_r != ggc_pkg::ST_IDLE);

  // Padding colors past the limit always count as blocked.
  assign blk_pad = {{(ggc_pkg::PAD_W - ggc_pkg::MAX_COLORS){1'b1}}, blocked_r};

  // Free colors in the current chunk, lowest one wins.
  always_comb begin
    free_bits = '0;
    pick      = '0;
    found     = 1'b0;
    cidx      = '0;
    for (int k = 0; k < ggc_pkg::CHUNK; k++) begin
      cidx = {scan_r, ggc_pkg::CHUNK_W'(k)};
      free_bits[k] = !blk_pad[cidx] && (cidx < color_count_r);
    end
    for (int k = ggc_pkg::CHUNK - 1; k >= 0; k--) begin
      if (free_bits[k]) begin
        found = 1'b1;
        pick  = ggc_pkg::CHUNK_W'(k);
      end
    end
  end

  // A stored color only counts when it is a real color.
  assign old_ok = vid_ok_r && (tbl_rdata != ggc_pkg::UNCOLORED) &&
                  (tbl_rdata < ggc_pkg::COLOR_W'(ggc_pkg::MAX_COLORS));

  // Memory addressing: the table reads the neighbor at accept, else the vertex.
  assign tbl_raddr = (state_r == ggc_pkg::ST_IDLE) ? in_neighbor_id[ggc_pkg::VTX_AW-1:0]
                                                   : vid_r[ggc_pkg::VTX_AW-1:0];
  assign pop_raddr = (state_r == ggc_pkg::ST_VCHK) ? tbl_rdata : chosen_r;

  // Sequencer.
  always_comb begin
    state_nxt       = state_r;
    clr_nxt         = clr_r;
    scan_nxt        = scan_r;
    chosen_nxt      = chosen_r;
    new_color_nxt   = new_color_r;
    old_nxt         = old_r;
    color_count_nxt = color_count_r;
    blocked_nxt     = blocked_r;
    tbl_we          = 1'b0;
    tbl_waddr       = vid_r[ggc_pkg::VTX_AW-1:0];
    tbl_wdata       = chosen_r;
    pop_we          = 1'b0;
    pop_waddr       = chosen_r;
    pop_wdata       = '0;
    out_load        = 1'b0;
    out_color_nxt   = chosen_r;
    out_pop_nxt     = '0;
    out_oob_nxt     = 1'b0;
    unique case (state_r)
      ggc_pkg::ST_CLEAR: begin
        tbl_we    = 1'b1;
        tbl_waddr = clr_r;
        tbl_wdata = ggc_pkg::UNCOLORED;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == {ggc_pkg::VTX_AW{1'b1}}) begin
          state_nxt = ggc_pkg::ST_IDLE;
        end
      end
      ggc_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = ggc_pkg::ST_NRD;
        end
      end
      ggc_pkg::ST_NRD: begin
        // Neighbor color is back from the table: mark it blocked.
        if (nb_ok_r && (tbl_rdata != ggc_pkg::UNCOLORED) &&
            (tbl_rdata < ggc_pkg::COLOR_W'(ggc_pkg::MAX_COLORS))) begin
          blocked_nxt[tbl_rdata] = 1'b1;
        end
        if (last_r) begin
          scan_nxt  = '0;
          state_nxt = ggc_pkg::ST_SCAN;
        end else begin
          state_nxt = ggc_pkg::ST_IDLE;
        end
      end
      ggc_pkg::ST_SCAN: begin
        if (found) begin
          chosen_nxt    = {scan_r, pick};
          new_color_nxt = 1'b0;
          blocked_nxt   = '0;
          state_nxt     = ggc_pkg::ST_VCHK;
        end else if (scan_r == ggc_pkg::SCAN_W'(ggc_pkg::NUM_CHUNKS - 1)) begin
          blocked_nxt = '0;
          if (color_count_r >= ggc_pkg::COLOR_W'(ggc_pkg::MAX_COLORS)) begin
            // Out of colors: report and leave table, count and populations alone; the blocked set is cleared.
            out_load      = 1'b1;
            out_color_nxt = ggc_pkg::UNCOLORED;
            out_pop_nxt   = '0;
            out_oob_nxt   = 1'b1;
            state_nxt     = ggc_pkg::ST_IDLE;
          end else begin
            chosen_nxt      = color_count_r;
            new_color_nxt   = 1'b1;
            color_count_nxt = color_count_r + 1'b1;
            state_nxt       = ggc_pkg::ST_VCHK;
          end
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end
      ggc_pkg::ST_VCHK: begin
        // Old color of the vertex is back; store the new one.
        tbl_we  = vid_ok_r;
        old_nxt = tbl_rdata;
        if (old_ok) begin
          state_nxt = ggc_pkg::ST_ODEC;
        end else begin
          state_nxt = ggc_pkg::ST_CRD;
        end
      end
      ggc_pkg::ST_ODEC: begin
        pop_we    = 1'b1;
        pop_waddr = old_r;
        pop_wdata = (pop_rdata != '0) ? pop_rdata - 1'b1 : '0;
        state_nxt = ggc_pkg::ST_CRD;
      end
      ggc_pkg::ST_CRD: begin
        state_nxt = ggc_pkg::ST_CINC;
      end
      ggc_pkg::ST_CINC: begin
        // A freshly opened color has no stored count yet.
        if (new_color_r) begin
          pop_wdata = ggc_pkg::POP_W'(1);
        end else if (pop_rdata == ggc_pkg::POP_MAX) begin
          pop_wdata = ggc_pkg::POP_MAX;
        end else begin
          pop_wdata = pop_rdata + 1'b1;
        end
        pop_we      = 1'b1;
        out_load    = 1'b1;
        out_pop_nxt = pop_wdata;
        state_nxt   = ggc_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = ggc_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ggc_pkg::ST_CLEAR;
      clr_r         <= '0;
      scan_r        <= '0;
      new_color_r   <= 1'b0;
      color_count_r <= '0;
      blocked_r     <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      clr_r         <= clr_nxt;
      scan_r        <= scan_nxt;
      new_color_r   <= new_color_nxt;
      color_count_r <= color_count_nxt;
      blocked_r     <= blocked_nxt;
      out_valid_r   <= out_load;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    chosen_r <= chosen_nxt;
    old_r    <= old_nxt;
    if (accept) begin
      vid_r    <= in_vertex_id;
      vid_ok_r <= ({1'b0, in_vertex_id} < (ggc_pkg::VID_W + 1)'(ggc_pkg::MAX_VERTICES));
      nb_ok_r  <= in_has_neighbor &&
                  ({1'b0, in_neighbor_id} < (ggc_pkg::VID_W + 1)'(ggc_pkg::MAX_VERTICES));
      last_r   <= in_last_neighbor;
    end
    if (out_load) begin
      out_vertex_r <= vid_r;
      out_color_r  <= out_color_nxt;
      out_count_r  <= color_count_r;
      out_pop_r    <= out_pop_nxt;
      out_oob_r    <= out_oob_nxt;
    end
  end

  // Vertex color table.
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[tbl_waddr] <= tbl_wdata;
    end
    tbl_rdata <= tbl_mem[tbl_raddr];
  end

  // Per-color population memory.
  always_ff @(posedge clk) begin
    if (pop_we) begin
      pop_mem[pop_waddr] <= pop_wdata;
    end
    pop_rdata <= pop_mem[pop_raddr];
  end

  assign out_valid            = out_valid_r;
  assign out_colored_vertex   = out_vertex_r;
  assign out_assigned_color   = out_color_r;
  assign out_colors_in_use    = out_count_r;
  assign out_color_population = out_pop_r;
  assign out_out_of_colors    = out_oob_r;

  // A granted color is always one of the opened colors.
  a_color_opened: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_out_of_colors |-> out_assigned_color < out_colors_in_use)
    else $error("granted color not below colors in use");

  // Running out of colors only happens at the limit, and reports no population.
  a_oob_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_out_of_colors |->
      out_colors_in_use == ggc_pkg::COLOR_W'(ggc_pkg::MAX_COLORS) &&
      out_color_population == '0 && out_assigned_color == ggc_pkg::UNCOLORED)
    else $error("out-of-colors result inconsistent");

  // A vertex that just took a color makes that color's population nonzero.
  a_pop_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_out_of_colors |-> out_color_population != '0)
    else $error("granted color has zero population");

  // The color count never passes the limit.
  a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
    color_count_r <= ggc_pkg::COLOR_W'(ggc_pkg::MAX_COLORS))
    else $error("color count above limit");

endmodule

>>> bench/tb_greedy_graph_coloring_core.sv
`timescale 1ns / 1ps

module tb_greedy_graph_coloring_core;

  localparam int IDLE_LIMIT   = 250000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RAND_ITEMS   = 880;
  localparam int PHASE_LEN    = 150;
  localparam int CLIQUE_N     = 20;
  localparam logic [ggc_pkg::VID_W-1:0] CLIQUE_BASE = 16'h9000;

  // One neighbor request as queued for the driver.
  typedef struct packed {
    logic [ggc_pkg::VID_W-1:0] vid;
    logic [ggc_pkg::VID_W-1:0] nid;
    logic                      has_nb;
    logic                      last;
    logic                      hold;
    logic [6:0]                gap;
  } nb_req_t;

  // One coloring report.
  typedef struct packed {
    logic [ggc_pkg::VID_W-1:0]   vertex;
    logic [ggc_pkg::COLOR_W-1:0] color;
    logic [ggc_pkg::COLOR_W-1:0] in_use;
    logic [ggc_pkg::POP_W-1:0]   pop;
    logic                        ooc;
  } color_rpt_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         start = 1'b0;
  logic                         busy;
  logic [ggc_pkg::VID_W-1:0]    in_vertex_id = '0;
  logic [ggc_pkg::VID_W-1:0]    in_neighbor_id = '0;
  logic                         in_has_neighbor = 1'b0;
  logic                         in_last_neighbor = 1'b0;
  logic                         out_valid;
  logic [ggc_pkg::VID_W-1:0]    out_colored_vertex;
  logic [ggc_pkg::COLOR_W-1:0]  out_assigned_color;
  logic [ggc_pkg::COLOR_W-1:0]  out_colors_in_use;
  logic [ggc_pkg::POP_W-1:0]    out_color_population;
  logic                         out_out_of_colors;

  nb_req_t    pending_reqs[$];
  color_rpt_t expected_colors[$];
  nb_req_t    cur_req;
  logic       took = 1'b0;
  int         n_items = 0;
  int         errors = 0;
  int         idle_cycles = 0;

  // Shadow of the coloring state.
  logic [ggc_pkg::COLOR_W-1:0]    color_tab [ggc_pkg::MAX_VERTICES];
  logic [ggc_pkg::MAX_COLORS-1:0] blocked_set;
  int                             n_colors;
  logic [ggc_pkg::POP_W-1:0]      color_pop [ggc_pkg::MAX_COLORS];

  greedy_graph_coloring_core u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_vertex_id         (in_vertex_id),
    .in_neighbor_id       (in_neighbor_id),
    .in_has_neighbor      (in_has_neighbor),
    .in_last_neighbor     (in_last_neighbor),
    .out_valid            (out_valid),
    .out_colored_vertex   (out_colored_vertex),
    .out_assigned_color   (out_assigned_color),
    .out_colors_in_use    (out_colors_in_use),
    .out_color_population (out_color_population),
    .out_out_of_colors    (out_out_of_colors)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Applies one accepted request to the shadow state and queues the report it causes.
  task automatic color_vertex(input nb_req_t r);
    logic [ggc_pkg::COLOR_W-1:0] nb_color;
    logic [ggc_pkg::COLOR_W-1:0] old_color;
    logic [ggc_pkg::COLOR_W-1:0] pick;
    color_rpt_t                  rpt;
    int                          j;
    if (r.has_nb && int'(r.nid) < ggc_pkg::MAX_VERTICES) begin
      nb_color = color_tab[r.nid];
      if (nb_color != ggc_pkg::UNCOLORED && int'(nb_color) < ggc_pkg::MAX_COLORS) begin
        blocked_set[nb_color] = 1'b1;
      end
    end
    if (r.last) begin
      // Walking downward leaves the lowest free opened color.
      pick = ggc_pkg::UNCOLORED;
      for (j = n_colors - 1; j >= 0; j--) begin
        if (!blocked_set[j]) begin
          pick = ggc_pkg::COLOR_W'(j);
        end
      end
      rpt.ooc = 1'b0;
      if (pick == ggc_pkg::UNCOLORED) begin
        if (n_colors >= ggc_pkg::MAX_COLORS) begin
          rpt.ooc = 1'b1;
        end else begin
          pick = ggc_pkg::COLOR_W'(n_colors);
          n_colors++;
        end
      end
      rpt.vertex = r.vid;
      rpt.color  = pick;
      rpt.in_use = ggc_pkg::COLOR_W'(n_colors);
      rpt.pop    = '0;
      if (!rpt.ooc) begin
        if (int'(r.vid) < ggc_pkg::MAX_VERTICES) begin
          old_color = color_tab[r.vid];
          if (old_color != ggc_pkg::UNCOLORED && int'(old_color) < ggc_pkg::MAX_COLORS &&
              color_pop[old_color] != 0) begin
            color_pop[old_color] = color_pop[old_color] - 1'b1;
          end
          color_tab[r.vid] = pick;
        end
        if (color_pop[pick] != ggc_pkg::POP_MAX) begin
          color_pop[pick] = color_pop[pick] + 1'b1;
        end
        rpt.pop = color_pop[pick];
      end
      blocked_set = '0;
      expected_colors.insert(expected_colors.size(), rpt);
    end
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // Queues one request; the sender's idle rate follows the phase of the run.
  task automatic push_req(input logic [ggc_pkg::VID_W-1:0] vid,
                          input logic [ggc_pkg::VID_W-1:0] nid,
                          input logic has_nb, input logic last, input logic hold);
    nb_req_t r;
    r.vid    = vid;
    r.nid    = nid;
    r.has_nb = has_nb;
    r.last   = last;
    r.hold   = hold;
    case ((n_items / PHASE_LEN) % 4)
      1: r.gap = 7'd61;
      3: r.gap = 7'd29;
      default: r.gap = 7'd0;
    endcase
    pending_reqs.insert(pending_reqs.size(), r);
    n_items++;
  endtask

  // Mostly a small pool so that neighbors tend to be colored already.
  function automatic logic [ggc_pkg::VID_W-1:0] pick_id();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 75) begin
      return ggc_pkg::VID_W'($urandom_range(63));
    end else if (sel < 90) begin
      return ggc_pkg::VID_W'($urandom);
    end else begin
      return 16'hFF00 | ggc_pkg::VID_W'($urandom_range(255));
    end
  endfunction

  // One vertex with random neighbors, now and then broken or noisy.
  task automatic add_random_vertex();
    logic [ggc_pkg::VID_W-1:0] vid;
    logic [ggc_pkg::VID_W-1:0] nid;
    logic                      has_nb;
    logic                      drop_last;
    logic                      hold_it;
    int                        n_nb;
    int                        k;
    vid       = pick_id();
    n_nb      = ($urandom_range(99) < 15) ? 0 : int'($urandom_range(1, 8));
    hold_it   = ($urandom_range(99) == 0);
    drop_last = ($urandom_range(99) < 4);
    if (n_nb == 0) begin
      push_req(vid, ggc_pkg::VID_W'($urandom), 1'b0, 1'b1, hold_it);
    end else begin
      for (k = 0; k < n_nb; k++) begin
        has_nb = ($urandom_range(99) >= 5);
        if ($urandom_range(99) < 15) begin
          nid = vid;
        end else if (!has_nb) begin
          nid = ggc_pkg::VID_W'($urandom);
        end else begin
          nid = pick_id();
        end
        if ($urandom_range(99) < 3) begin
          vid = pick_id();
        end
        push_req(vid, nid, has_nb, (k == n_nb - 1) && !drop_last, hold_it && k == 0);
      end
    end
  endtask

  // A clique needs as many distinct colors as it has members, so the search
  // has to run past its first chunk.
  task automatic add_clique();
    int k;
    int j;
    for (k = 0; k < CLIQUE_N; k++) begin
      if (k == 0) begin
        push_req(CLIQUE_BASE, ggc_pkg::VID_W'($urandom), 1'b0, 1'b1, 1'b0);
      end else begin
        for (j = 0; j < k; j++) begin
          push_req(CLIQUE_BASE + ggc_pkg::VID_W'(k),
                   CLIQUE_BASE + ggc_pkg::VID_W'((k == CLIQUE_N - 1) ? k - 1 - j : j),
                   1'b1, j == k - 1, j == 0 && k % 8 == 0);
        end
      end
    end
    // The last member is colored again with one member left out of its list.
    for (j = 0; j < CLIQUE_N - 1; j++) begin
      if (j != 7) begin
        push_req(CLIQUE_BASE + ggc_pkg::VID_W'(CLIQUE_N - 1),
                 CLIQUE_BASE + ggc_pkg::VID_W'(j), 1'b1, j == CLIQUE_N - 2, 1'b0);
      end
    end
  endtask

  // Directed vertices: empty vertex, extreme ids, self neighbor, recoloring,
  // ignored neighbor, repeated neighbors.
  task automatic add_directed();
    push_req(16'h0000, 16'h0000, 1'b0, 1'b1, 1'b0);
    push_req(16'hFFFF, 16'h0000, 1'b1, 1'b1, 1'b0);
    push_req(16'h0001, 16'hFFFF, 1'b1, 1'b0, 1'b0);
    push_req(16'h0001, 16'h0000, 1'b1, 1'b1, 1'b0);
    push_req(16'h0002, 16'h0005, 1'b1, 1'b1, 1'b0);
    push_req(16'h0000, 16'h0000, 1'b1, 1'b1, 1'b1);
    push_req(16'h0000, 16'hFFFF, 1'b0, 1'b1, 1'b0);
    push_req(16'h0003, 16'h0000, 1'b0, 1'b1, 1'b0);
    push_req(16'h0004, 16'h0000, 1'b1, 1'b0, 1'b0);
    push_req(16'h0004, 16'hFFFF, 1'b0, 1'b0, 1'b0);
    push_req(16'h0004, 16'h0001, 1'b1, 1'b1, 1'b0);
    push_req(16'h0005, 16'h0000, 1'b1, 1'b0, 1'b0);
    push_req(16'h0005, 16'h0000, 1'b1, 1'b1, 1'b1);
    push_req(16'hAAAA, 16'h5555, 1'b1, 1'b1, 1'b0);
    push_req(16'h5555, 16'hAAAA, 1'b1, 1'b1, 1'b0);
    push_req(16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b0);
  endtask

  // Driver: a request stays on the ports until it is taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || took) begin
      if (pending_reqs.size() != 0 &&
          !(pending_reqs[0].hold && expected_colors.size() != 0) &&
          $urandom_range(99) >= pending_reqs[0].gap) begin
        cur_req = pending_reqs.pop_front();
        start            <= 1'b1;
        in_vertex_id     <= cur_req.vid;
        in_neighbor_id   <= cur_req.nid;
        in_has_neighbor  <= cur_req.has_nb;
        in_last_neighbor <= cur_req.last;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: check reports, predict taken requests, and watch for a hang.
  always @(posedge clk) begin
    color_rpt_t want;
    took = start && !busy;
    if (rst_n && out_valid) begin
      if (expected_colors.size() == 0) begin
        $display("%0t ns: unexpected report, vertex %0d color %0d", $time,
                 out_colored_vertex, out_assigned_color);
        errors++;
      end else begin
        want = expected_colors.pop_front();
        check_field("colored_vertex", 32'(want.vertex), 32'(out_colored_vertex));
        check_field("assigned_color", 32'(want.color), 32'(out_assigned_color));
        check_field("colors_in_use", 32'(want.in_use), 32'(out_colors_in_use));
        check_field("color_population", 32'(want.pop), 32'(out_color_population));
        check_field("out_of_colors", 32'(want.ooc), 32'(out_out_of_colors));
      end
    end
    if (rst_n && took) begin
      color_vertex(cur_req);
    end
    if (took || (rst_n && out_valid)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("greedy_graph_coloring_core test failed");
      $finish;
    end
  end

  initial begin
    int i;
    for (i = 0; i < ggc_pkg::MAX_VERTICES; i++) begin
      color_tab[i] = ggc_pkg::UNCOLORED;
    end
    for (i = 0; i < ggc_pkg::MAX_COLORS; i++) begin
      color_pop[i] = '0;
    end
    blocked_set = '0;
    n_colors    = 0;

    add_directed();
    while (n_items < RAND_ITEMS) begin
      add_random_vertex();
    end
    add_clique();
    for (i = 0; i < 40; i++) begin
      add_random_vertex();
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Wait for every request to be taken and every report to arrive.
    while (pending_reqs.size() != 0 || start || expected_colors.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("greedy_graph_coloring_core test passed");
    end else begin
      $display("greedy_graph_coloring_core test failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/ggc_pkg.sv
hw/rtl/greedy_graph_coloring_core.sv
bench/tb_greedy_graph_coloring_core.sv
